// ===== src/text_console_cursor_scroll_top_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the text console
// Concurrent checks; the macros expand to nothing when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_TOP_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define TCCS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tccs: assertion failed");
// next-cycle implication
`define TCCS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tccs: assertion failed");
`else
`define TCCS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define TCCS_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== src/tccs_pkg.sv =====
// ---------------------------------------------------------------------------
// tccs_pkg
// Geometry, codes and controller/datapath interface types of the text console.
// ---------------------------------------------------------------------------
`default_nettype none

package tccs_pkg;

    // screen geometry
    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int CELL_COUNT  = COLUMNS * ROWS;
    localparam int SHIFT_CELLS = CELL_COUNT - COLUMNS;   // cells moved by a scroll
    localparam int TAB_STOP    = 8;

    localparam int CW = $clog2(COLUMNS);          // stored column
    localparam int RW = $clog2(ROWS);             // stored row
    localparam int AW = $clog2(CELL_COUNT);       // cell address
    localparam int SW = $clog2(CELL_COUNT + 1);   // sweep counter, holds CELL_COUNT

    // fixed field widths
    localparam int CMD_W  = 2;
    localparam int CHAR_W = 8;
    localparam int IDX_W  = 11;
    localparam int POS_W  = 11;
    localparam int ATTR_W = 8;
    localparam int CELL_W = ATTR_W + CHAR_W;

    // character codes
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_LAST  = 8'h7F;

    localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'h0F;
    localparam logic [CELL_W-1:0] RESET_BLANK = {ATTR_RESET, CH_SPACE};

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        SWP_INIT,     // post-reset fill with the reset blank
        SWP_FILL,     // clear command, blank with current attribute
        SWP_SCROLL    // move rows up, blank the bottom row
    } sweep_mode_t;

    typedef struct packed {
        logic        latch_in;
        logic        exec;
        logic        sweep_clr;
        logic        sweep_step;
        sweep_mode_t sweep_mode;
        logic        load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic need_scroll;
        logic sweep_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== src/tccs_ctrl.sv =====
// ---------------------------------------------------------------------------
// tccs_ctrl
// Sequencer: reset fill, command execute, scroll/clear sweeps, result hand-off.
// ---------------------------------------------------------------------------
`default_nettype none

module tccs_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire tccs_pkg::dp_status_t   sts,
    output tccs_pkg::ctrl_cmd_t         ctl
);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL,
        ST_FILL,
        ST_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        ctl.sweep_mode = tccs_pkg::SWP_INIT;
        unique case (state_reg)
            ST_INIT:
            begin
                ctl.sweep_step = 1'b1;
                ctl.sweep_mode = tccs_pkg::SWP_INIT;
                if (sts.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.latch_in = 1'b1;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                ctl.exec = 1'b1;
                unique case (sts.cmd)
                    tccs_pkg::CMD_PUT:
                    begin
                        if (sts.need_scroll)
                        begin
                            ctl.sweep_clr = 1'b1;
                            state_next    = ST_SCROLL;
                        end
                        else
                        begin
                            state_next = ST_RESULT;
                        end
                    end
                    tccs_pkg::CMD_CLEAR:
                    begin
                        ctl.sweep_clr = 1'b1;
                        state_next    = ST_FILL;
                    end
                    default:
                    begin
                        state_next = ST_RESULT;
                    end
                endcase
            end
            ST_SCROLL:
            begin
                ctl.sweep_step = 1'b1;
                ctl.sweep_mode = tccs_pkg::SWP_SCROLL;
                if (sts.sweep_last)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_FILL:
            begin
                ctl.sweep_step = 1'b1;
                ctl.sweep_mode = tccs_pkg::SWP_FILL;
                if (sts.sweep_last)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (sts.out_free)
                begin
                    ctl.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/tccs_datapath.sv =====
// ---------------------------------------------------------------------------
// tccs_datapath
// Cursor, attribute register, screen memory, sweep counter and output stage.
// ---------------------------------------------------------------------------
`default_nettype none
`include "text_console_cursor_scroll_top_assert.svh"

module tccs_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire tccs_pkg::ctrl_cmd_t               ctl,
    output tccs_pkg::dp_status_t                   sts,
    input  wire logic [tccs_pkg::CMD_W-1:0]        cmd,
    input  wire logic [tccs_pkg::CHAR_W-1:0]       char_code,
    input  wire logic [tccs_pkg::IDX_W-1:0]        cell_index,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [tccs_pkg::ATTR_W-1:0]       cfg_data,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [tccs_pkg::POS_W-1:0]             cursor_pos,
    output logic [tccs_pkg::CELL_W-1:0]            cell_data,
    output logic                                   scrolled
);

    localparam int CW     = tccs_pkg::CW;
    localparam int RW     = tccs_pkg::RW;
    localparam int AW     = tccs_pkg::AW;
    localparam int SW     = tccs_pkg::SW;
    localparam int CELL_W = tccs_pkg::CELL_W;

    localparam logic [CW:0]   COL_LIMIT = (CW+1)'(tccs_pkg::COLUMNS);
    localparam logic [CW:0]   TAB_INC   = (CW+1)'(tccs_pkg::TAB_STOP);
    localparam logic [CW:0]   TAB_MASK  = ~((CW+1)'(tccs_pkg::TAB_STOP - 1));
    localparam logic [CW:0]   COL_ONE   = (CW+1)'(1);
    localparam logic [RW:0]   ROW_LIMIT = (RW+1)'(tccs_pkg::ROWS);
    localparam logic [RW-1:0] ROW_LAST  = RW'(tccs_pkg::ROWS - 1);
    localparam logic [SW-1:0] SW_SHIFT  = SW'(tccs_pkg::SHIFT_CELLS);
    localparam logic [SW-1:0] SW_COLS   = SW'(tccs_pkg::COLUMNS);
    localparam logic [SW-1:0] SW_LAST   = SW'(tccs_pkg::CELL_COUNT - 1);
    localparam logic [SW-1:0] SW_END    = SW'(tccs_pkg::CELL_COUNT);
    localparam logic [SW-1:0] SW_ONE    = SW'(1);

    // latched item
    tccs_pkg::cmd_t                   cmd_reg;
    logic [tccs_pkg::CHAR_W-1:0]      ch_reg;
    logic [tccs_pkg::IDX_W-1:0]       idx_reg;

    logic [tccs_pkg::ATTR_W-1:0]      attr_reg;
    logic [CW-1:0]                    cur_col_reg;
    logic [RW-1:0]                    cur_row_reg;
    logic                             scr_reg;
    logic [SW-1:0]                    swp_cnt_reg;

    logic [CELL_W-1:0]                mem [tccs_pkg::CELL_COUNT];
    logic [CELL_W-1:0]                rdata_reg;

    logic                             out_valid_reg;
    logic [tccs_pkg::POS_W-1:0]       pos_out_reg;
    logic [CELL_W-1:0]                data_out_reg;
    logic                             scr_out_reg;

    logic [CW:0]                      col_ext;
    logic [CW:0]                      col_n;
    logic [RW:0]                      row_n;
    logic                             row_inc;
    logic                             put_char;
    logic                             need_scroll;
    logic [AW-1:0]                    cur_pos;
    logic                             idx_ok;
    logic [CELL_W-1:0]                blank_attr;
    logic [SW-1:0]                    swp_km1;

    logic                             mem_we;
    logic [AW-1:0]                    mem_waddr;
    logic [CELL_W-1:0]                mem_wdata;
    logic                             mem_re;
    logic [AW-1:0]                    mem_raddr;

    assign cfg_ready  = 1'b1;
    assign blank_attr = {attr_reg, tccs_pkg::CH_SPACE};
    assign cur_pos    = AW'(cur_row_reg) * AW'(tccs_pkg::COLUMNS) + AW'(cur_col_reg);
    assign idx_ok     = 32'(idx_reg) < tccs_pkg::CELL_COUNT;
    assign swp_km1    = swp_cnt_reg - SW_ONE;

    // next cursor for a put
    always_comb
    begin
        col_ext  = {1'b0, cur_col_reg};
        col_n    = col_ext;
        row_inc  = 1'b0;
        put_char = 1'b0;
        case (ch_reg) inside
            tccs_pkg::CH_BS:
            begin
                if (cur_col_reg != '0)
                begin
                    col_n = col_ext - COL_ONE;
                end
            end
            tccs_pkg::CH_TAB:
            begin
                col_n = (col_ext + TAB_INC) & TAB_MASK;
            end
            tccs_pkg::CH_CR:
            begin
                col_n = '0;
            end
            tccs_pkg::CH_LF:
            begin
                col_n   = '0;
                row_inc = 1'b1;
            end
            [tccs_pkg::CH_SPACE:tccs_pkg::CH_LAST]:
            begin
                col_n    = col_ext + COL_ONE;
                put_char = 1'b1;
            end
            default:
            begin
                col_n = col_ext;
            end
        endcase
        // wrap past the last column
        if (col_n >= COL_LIMIT)
        begin
            col_n   = '0;
            row_inc = 1'b1;
        end
        row_n       = {1'b0, cur_row_reg} + (RW+1)'(row_inc);
        need_scroll = (row_n >= ROW_LIMIT);
    end

    // memory port selection
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = blank_attr;
        mem_re    = 1'b0;
        mem_raddr = '0;
        if (ctl.exec)
        begin
            case (cmd_reg)
                tccs_pkg::CMD_PUT:
                begin
                    if (put_char)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = cur_pos;
                        mem_wdata = {attr_reg, ch_reg};
                    end
                end
                tccs_pkg::CMD_READ:
                begin
                    if (idx_ok)
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = AW'(idx_reg);
                    end
                end
                default:
                begin
                    mem_re = 1'b0;
                end
            endcase
        end
        else if (ctl.sweep_step)
        begin
            case (ctl.sweep_mode)
                tccs_pkg::SWP_INIT:
                begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(swp_cnt_reg);
                    mem_wdata = tccs_pkg::RESET_BLANK;
                end
                tccs_pkg::SWP_FILL:
                begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(swp_cnt_reg);
                    mem_wdata = blank_attr;
                end
                tccs_pkg::SWP_SCROLL:
                begin
                    // read one row ahead, write the cell read last cycle
                    if (swp_cnt_reg < SW_SHIFT)
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = AW'(swp_cnt_reg + SW_COLS);
                    end
                    if (swp_cnt_reg != '0)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = AW'(swp_km1);
                        mem_wdata = (swp_km1 < SW_SHIFT) ? rdata_reg : blank_attr;
                    end
                end
                default:
                begin
                    mem_we = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // item latch and output payload
    always_ff @(posedge clk)
    begin
        if (ctl.latch_in)
        begin
            cmd_reg <= tccs_pkg::cmd_t'(cmd);
            ch_reg  <= char_code;
            idx_reg <= cell_index;
        end
        if (ctl.load_out)
        begin
            pos_out_reg  <= tccs_pkg::POS_W'(cur_pos);
            data_out_reg <= ((cmd_reg == tccs_pkg::CMD_READ) && idx_ok) ? rdata_reg : '0;
            scr_out_reg  <= scr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg      <= tccs_pkg::ATTR_RESET;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            scr_reg       <= 1'b0;
            swp_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                attr_reg <= cfg_data;
            end

            if (ctl.latch_in)
            begin
                scr_reg <= 1'b0;
            end
            else if (ctl.exec)
            begin
                case (cmd_reg)
                    tccs_pkg::CMD_PUT:
                    begin
                        cur_col_reg <= col_n[CW-1:0];
                        cur_row_reg <= need_scroll ? ROW_LAST : row_n[RW-1:0];
                        scr_reg     <= need_scroll;
                    end
                    tccs_pkg::CMD_CLEAR:
                    begin
                        cur_col_reg <= '0;
                        cur_row_reg <= '0;
                    end
                    default:
                    begin
                        scr_reg <= 1'b0;
                    end
                endcase
            end

            if (ctl.sweep_clr)
            begin
                swp_cnt_reg <= '0;
            end
            else if (ctl.sweep_step)
            begin
                swp_cnt_reg <= swp_cnt_reg + SW_ONE;
            end

            if (ctl.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        sts.cmd         = cmd_reg;
        sts.need_scroll = need_scroll;
        sts.out_free    = !out_valid_reg || out_ready;
        if (ctl.sweep_mode == tccs_pkg::SWP_SCROLL)
        begin
            sts.sweep_last = (swp_cnt_reg == SW_END);
        end
        else
        begin
            sts.sweep_last = (swp_cnt_reg == SW_LAST);
        end
    end

    assign out_valid  = out_valid_reg;
    assign cursor_pos = pos_out_reg;
    assign cell_data  = data_out_reg;
    assign scrolled   = scr_out_reg;

    // a result is only loaded into a free output stage
    `TCCS_ASSERT_IMP(a_load_free, clk, rst_n, ctl.load_out, !out_valid_reg || out_ready)
    // a scrolling put leaves the cursor on the bottom row
    `TCCS_ASSERT_NXT(a_scroll_row, clk, rst_n, ctl.exec && (cmd_reg == tccs_pkg::CMD_PUT) && need_scroll, cur_row_reg == ROW_LAST)
    // column stays on screen after any command
    `TCCS_ASSERT_NXT(a_col_range, clk, rst_n, ctl.exec, 32'(cur_col_reg) < tccs_pkg::COLUMNS)
    // scroll copy never reads the cell it is writing
    `TCCS_ASSERT_IMP(a_rw_split, clk, rst_n, mem_we && mem_re, mem_waddr != mem_raddr)

endmodule

`default_nettype wire

// ===== src/text_console_cursor_scroll_top.sv =====
// An input beat is latched in IDLE, executed in EXEC and handed to the output
// stage from RESULT once it is free; in_ready is high only in IDLE. A scrolling
// put adds a SCROLL sweep and a clear a FILL sweep, one screen cell per cycle.
// Reset: cursor homed, attribute 0x0F; a fill pass then blanks the screen
// memory with in_ready low. Config writes are taken at any time.
// ---------------------------------------------------------------------------
// text_console_cursor_scroll_top
// Character-cell text console: sequencer plus cursor/screen-memory datapath.
// ---------------------------------------------------------------------------
`default_nettype none

module text_console_cursor_scroll_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // command beats
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [tccs_pkg::CMD_W-1:0]     cmd,
    input  wire logic [tccs_pkg::CHAR_W-1:0]    char_code,
    input  wire logic [tccs_pkg::IDX_W-1:0]     cell_index,
    // attribute register write
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [tccs_pkg::ATTR_W-1:0]    cfg_data,
    // result beats
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [tccs_pkg::POS_W-1:0]          cursor_pos,
    output logic [tccs_pkg::CELL_W-1:0]         cell_data,
    output logic                                scrolled
);

    // Controller: INIT fill -> IDLE -> EXEC -> optional SCROLL or FILL -> RESULT.
    // The datapath owns the single-write, single-read screen memory; a scroll
    // reads one row ahead and writes the previous cell each cycle.
    tccs_pkg::ctrl_cmd_t  ctl;
    tccs_pkg::dp_status_t sts;

    tccs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .ctl      (ctl)
    );

    tccs_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .sts        (sts),
        .cmd        (cmd),
        .char_code  (char_code),
        .cell_index (cell_index),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cursor_pos (cursor_pos),
        .cell_data  (cell_data),
        .scrolled   (scrolled)
    );

endmodule

`default_nettype wire
